[src/fcdc_pkg.sv]
// ----------------------------------------------------------------------------
// fcdc_pkg
// Shared types, codes, curve tables and helpers for the fan curve duty
// controller.
// ----------------------------------------------------------------------------
package fcdc_pkg;

  localparam int CURVE_POINTS   = 5;
  localparam int BUILTIN_POINTS = 5;
  localparam int BLT_IDX_W      = $clog2(BUILTIN_POINTS);
  localparam int CFG_ADDR_W     = 2;

  localparam logic [6:0] TEMP_MAX     = 7'd125;
  localparam logic [6:0] HOT_LIMIT    = 7'd95;
  localparam logic [6:0] FULL_DUTY    = 7'd100;
  localparam logic [6:0] MANUAL_RESET = 7'd40;
  localparam logic [7:0] RAW_FLOOR    = 8'd63;
  // 2^22 / 100, rounded up; exact floor for every numerator up to 25500
  localparam logic [15:0] RECIP_100   = 16'd41944;

  localparam logic [63:0] CUSTOM_T_RESET = 64'd396517456941;
  localparam logic [63:0] CUSTOM_D_RESET = 64'd430927064345;

  // fan modes
  localparam logic [2:0] MODE_AUTO   = 3'd0;
  localparam logic [2:0] MODE_QUIET  = 3'd1;
  localparam logic [2:0] MODE_PERF   = 3'd2;
  localparam logic [2:0] MODE_MANUAL = 3'd4;

  // configuration register indexes
  localparam logic [CFG_ADDR_W-1:0] REG_FAN_MODE     = 2'd0;
  localparam logic [CFG_ADDR_W-1:0] REG_MANUAL_DUTY  = 2'd1;
  localparam logic [CFG_ADDR_W-1:0] REG_CURVE_TEMPS  = 2'd2;
  localparam logic [CFG_ADDR_W-1:0] REG_CURVE_DUTIES = 2'd3;

  // curve selection
  localparam logic [1:0] CURVE_QUIET  = 2'd0;
  localparam logic [1:0] CURVE_PERF   = 2'd1;
  localparam logic [1:0] CURVE_CUSTOM = 2'd2;

  // profile requests
  localparam logic [1:0] PROF_NONE     = 2'd0;
  localparam logic [1:0] PROF_QUIET    = 2'd1;
  localparam logic [1:0] PROF_BALANCED = 2'd2;
  localparam logic [1:0] PROF_PERF     = 2'd3;

  localparam logic [7:0] QUIET_T [BUILTIN_POINTS] = '{8'd45, 8'd60, 8'd72, 8'd82, 8'd92};
  localparam logic [7:0] QUIET_D [BUILTIN_POINTS] = '{8'd0, 8'd30, 8'd45, 8'd70, 8'd100};
  localparam logic [7:0] PERF_T  [BUILTIN_POINTS] = '{8'd40, 8'd55, 8'd68, 8'd78, 8'd90};
  localparam logic [7:0] PERF_D  [BUILTIN_POINTS] = '{8'd45, 8'd65, 8'd85, 8'd100, 8'd100};

  typedef struct packed {
    logic [7:0] cpu_temp_raw;
    logic       cpu_read_ok;
    logic [7:0] gpu_temp_raw;
    logic       gpu_read_ok;
  } in_item_t;

  typedef struct packed {
    logic       action;
    logic [6:0] duty_percent;
    logic [7:0] duty_raw;
    logic [1:0] profile_request;
    logic       failsafe;
    logic [6:0] hottest_temp;
  } out_item_t;

  typedef struct packed {
    logic       start;
    logic [1:0] sel;
    logic [6:0] temp;
  } curve_req_t;

  typedef struct packed {
    logic       done;
    logic [6:0] pct;
  } curve_rsp_t;

  function automatic logic [7:0] blt_temp(input logic [1:0] sel,
                                          input logic [BLT_IDX_W-1:0] idx);
    return (sel == CURVE_PERF) ? PERF_T[idx] : QUIET_T[idx];
  endfunction

  function automatic logic [7:0] blt_duty(input logic [1:0] sel,
                                          input logic [BLT_IDX_W-1:0] idx);
    return (sel == CURVE_PERF) ? PERF_D[idx] : QUIET_D[idx];
  endfunction

  // percent (0..100) to raw byte: zero stays zero, else pct*255/100 with a floor
  function automatic logic [7:0] raw_of_pct(input logic [6:0] pct);
    logic [14:0] scaled;
    logic [30:0] prod;
    logic [7:0]  raw;
    scaled = {pct, 8'd0} - {8'd0, pct};
    prod   = 31'(scaled) * 31'(RECIP_100);
    raw    = prod[29:22];
    if (pct == 7'd0) begin
      raw = 8'd0;
    end else if (raw < RAW_FLOOR) begin
      raw = RAW_FLOOR;
    end
    return raw;
  endfunction

endpackage

[src/fcdc_curve.sv]
// ----------------------------------------------------------------------------
// fcdc_curve
// Curve lookup sequencer: scans the curve points one per cycle, then runs
// one multiply and a restoring divider to interpolate the duty.
// ----------------------------------------------------------------------------
module fcdc_curve #(
  parameter int CurvePoints = fcdc_pkg::CURVE_POINTS
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  fcdc_pkg::curve_req_t       req,
  input  logic [8*CurvePoints-1:0]   curve_temps,
  input  logic [8*CurvePoints-1:0]   curve_duties,
  output fcdc_pkg::curve_rsp_t       rsp
);

  localparam int MaxPts = (CurvePoints > fcdc_pkg::BUILTIN_POINTS) ?
                          CurvePoints : fcdc_pkg::BUILTIN_POINTS;
  localparam int IdxW   = $clog2(MaxPts);

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_SCAN = 3'd1;
  localparam logic [2:0] S_MUL  = 3'd2;
  localparam logic [2:0] S_DIV  = 3'd3;
  localparam logic [2:0] S_ADD  = 3'd4;
  localparam logic [2:0] S_FIN  = 3'd5;

  logic [2:0]      state_r, state_nxt;
  logic [1:0]      sel_r, sel_nxt;
  logic [6:0]      temp_r, temp_nxt;
  logic [IdxW-1:0] idx_r, idx_nxt;
  logic [7:0]      t_prev_r, t_prev_nxt;
  logic [7:0]      d_prev_r, d_prev_nxt;
  logic [7:0]      delta_r, delta_nxt;
  logic [7:0]      rise_mag_r, rise_mag_nxt;
  logic            neg_r, neg_nxt;
  logic [7:0]      span_r, span_nxt;
  logic [15:0]     quo_r, quo_nxt;
  logic [7:0]      rem_r, rem_nxt;
  logic [3:0]      cnt_r, cnt_nxt;
  logic [9:0]      r_r, r_nxt;

  logic [7:0]      ct [MaxPts];
  logic [7:0]      cd [MaxPts];
  logic [7:0]      t_cur, d_cur;
  logic [IdxW-1:0] last_idx;
  logic [8:0]      span, rise, rise_abs;
  logic            span_pos;
  logic [8:0]      rem_sh;
  logic            ge;
  logic [6:0]      pct_clamped;

  for (genvar g = 0; g < MaxPts; g++) begin : g_unpack
    if (g < CurvePoints) begin : g_used
      assign ct[g] = curve_temps[8*g +: 8];
      assign cd[g] = curve_duties[8*g +: 8];
    end else begin : g_pad
      assign ct[g] = 8'd0;
      assign cd[g] = 8'd0;
    end
  end

  always_comb begin
    if (sel_r == fcdc_pkg::CURVE_CUSTOM) begin
      t_cur    = ct[idx_r];
      d_cur    = cd[idx_r];
      last_idx = IdxW'(CurvePoints - 1);
    end else begin
      t_cur    = fcdc_pkg::blt_temp(sel_r, idx_r[fcdc_pkg::BLT_IDX_W-1:0]);
      d_cur    = fcdc_pkg::blt_duty(sel_r, idx_r[fcdc_pkg::BLT_IDX_W-1:0]);
      last_idx = IdxW'(fcdc_pkg::BUILTIN_POINTS - 1);
    end
  end

  assign span     = {1'b0, t_cur} - {1'b0, t_prev_r};
  assign span_pos = !span[8] && (span != 9'd0);
  assign rise     = {1'b0, d_cur} - {1'b0, d_prev_r};
  assign rise_abs = rise[8] ? (9'd0 - rise) : rise;

  // one restoring divide step per cycle
  assign rem_sh = {rem_r, quo_r[15]};
  assign ge     = rem_sh >= {1'b0, span_r};

  always_comb begin
    if (r_r[9]) begin
      pct_clamped = 7'd0;
    end else if (r_r > {3'd0, fcdc_pkg::FULL_DUTY}) begin
      pct_clamped = fcdc_pkg::FULL_DUTY;
    end else begin
      pct_clamped = r_r[6:0];
    end
  end

  assign rsp.done = (state_r == S_FIN);
  assign rsp.pct  = pct_clamped;

  always_comb begin
    state_nxt    = state_r;
    sel_nxt      = sel_r;
    temp_nxt     = temp_r;
    idx_nxt      = idx_r;
    t_prev_nxt   = t_prev_r;
    d_prev_nxt   = d_prev_r;
    delta_nxt    = delta_r;
    rise_mag_nxt = rise_mag_r;
    neg_nxt      = neg_r;
    span_nxt     = span_r;
    quo_nxt      = quo_r;
    rem_nxt      = rem_r;
    cnt_nxt      = cnt_r;
    r_nxt        = r_r;
    unique case (state_r)
      S_IDLE: begin
        if (req.start) begin
          sel_nxt  = req.sel;
          temp_nxt = req.temp;
          idx_nxt  = '0;
          if (req.temp >= fcdc_pkg::HOT_LIMIT) begin
            r_nxt     = {3'd0, fcdc_pkg::FULL_DUTY};
            state_nxt = S_FIN;
          end else begin
            state_nxt = S_SCAN;
          end
        end
      end
      S_SCAN: begin
        if ({1'b0, temp_r} <= t_cur) begin
          if (idx_r == '0 || !span_pos) begin
            r_nxt     = {2'd0, d_cur};
            state_nxt = S_FIN;
          end else begin
            delta_nxt    = {1'b0, temp_r} - t_prev_r;
            rise_mag_nxt = rise_abs[7:0];
            neg_nxt      = rise[8];
            span_nxt     = span[7:0];
            state_nxt    = S_MUL;
          end
        end else if (idx_r == last_idx) begin
          r_nxt     = {2'd0, d_cur};
          state_nxt = S_FIN;
        end else begin
          t_prev_nxt = t_cur;
          d_prev_nxt = d_cur;
          idx_nxt    = idx_r + IdxW'(1);
        end
      end
      S_MUL: begin
        quo_nxt   = delta_r * rise_mag_r;
        rem_nxt   = 8'd0;
        cnt_nxt   = 4'd0;
        state_nxt = S_DIV;
      end
      S_DIV: begin
        rem_nxt = ge ? 8'(rem_sh - {1'b0, span_r}) : rem_sh[7:0];
        quo_nxt = {quo_r[14:0], ge};
        cnt_nxt = cnt_r + 4'd1;
        if (cnt_r == 4'd15) begin
          state_nxt = S_ADD;
        end
      end
      S_ADD: begin
        // truncate toward zero: apply the sign to the magnitude quotient
        r_nxt     = neg_r ? ({2'd0, d_prev_r} - {2'd0, quo_r[7:0]})
                          : ({2'd0, d_prev_r} + {2'd0, quo_r[7:0]});
        state_nxt = S_FIN;
      end
      S_FIN: begin
        state_nxt = S_IDLE;
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_ff @(posedge clk) begin
    sel_r      <= sel_nxt;
    temp_r     <= temp_nxt;
    idx_r      <= idx_nxt;
    t_prev_r   <= t_prev_nxt;
    d_prev_r   <= d_prev_nxt;
    delta_r    <= delta_nxt;
    rise_mag_r <= rise_mag_nxt;
    neg_r      <= neg_nxt;
    span_r     <= span_nxt;
    quo_r      <= quo_nxt;
    rem_r      <= rem_nxt;
    cnt_r      <= cnt_nxt;
    r_r        <= r_nxt;
  end

endmodule

[src/fan_curve_duty_controller_core.sv]
// ----------------------------------------------------------------------------
// fan_curve_duty_controller_core
// Fan duty controller: in the curve modes, picks the hottest valid sensor
// reading and maps it to a fan duty through a built-in or configurable piecewise linear curve.
// ----------------------------------------------------------------------------
// One control tick is taken per transfer on the input channel and gives one
// result on the output channel. Auto, manual and no-valid-sensor ticks pass
// from the transfer through ST_PUSH into the output register. A curve tick
// first waits in ST_CURVE for fcdc_curve, which runs the point scan (one
// point a cycle), one 8x8 multiply and a restoring divider, and then goes
// through ST_PUSH. in_stall is high from the transfer until the result is
// loaded into the output register; a result may sit there under out_stall
// while the next tick is taken.
// Configuration writes are taken on any cycle and must only happen while the
// block is idle.
module fan_curve_duty_controller_core #(
  parameter int CurvePoints = fcdc_pkg::CURVE_POINTS
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_valid,
  output logic                              in_stall,
  input  fcdc_pkg::in_item_t                in_data,
  output logic                              out_valid,
  input  logic                              out_stall,
  output fcdc_pkg::out_item_t               out_data,
  input  logic                              cfg_we,
  input  logic [fcdc_pkg::CFG_ADDR_W-1:0]   cfg_index,
  input  logic [8*CurvePoints-1:0]          cfg_wdata
);

  localparam int CurveW = 8 * CurvePoints;
  localparam logic [CurveW-1:0] TempsRst  = CurveW'(fcdc_pkg::CUSTOM_T_RESET);
  localparam logic [CurveW-1:0] DutiesRst = CurveW'(fcdc_pkg::CUSTOM_D_RESET);

  localparam logic [1:0] ST_IDLE  = 2'd0;
  localparam logic [1:0] ST_CURVE = 2'd1;
  localparam logic [1:0] ST_PUSH  = 2'd2;

  logic [2:0]          fan_mode_r;
  logic [6:0]          manual_duty_r;
  logic [CurveW-1:0]   curve_temps_r;
  logic [CurveW-1:0]   curve_duties_r;

  logic [1:0]          state_r, state_nxt;
  logic                owned_r, owned_nxt;
  fcdc_pkg::out_item_t res_r, res_nxt;
  logic                out_valid_r, out_valid_nxt;
  fcdc_pkg::out_item_t out_r, out_nxt;

  fcdc_pkg::curve_req_t curve_req;
  fcdc_pkg::curve_rsp_t curve_rsp;

  logic       accept;
  logic       cpu_ok, gpu_ok;
  logic [6:0] hot;
  logic       any_ok;
  logic       out_free;

  assign accept   = in_valid && !in_stall;
  assign in_stall = (state_r != ST_IDLE);
  assign out_free = !out_valid_r || !out_stall;

  assign cpu_ok = in_data.cpu_read_ok && (in_data.cpu_temp_raw != 8'd0) &&
                  (in_data.cpu_temp_raw <= {1'b0, fcdc_pkg::TEMP_MAX});
  assign gpu_ok = in_data.gpu_read_ok && (in_data.gpu_temp_raw != 8'd0) &&
                  (in_data.gpu_temp_raw <= {1'b0, fcdc_pkg::TEMP_MAX});
  assign any_ok = cpu_ok || gpu_ok;

  always_comb begin
    priority if (cpu_ok && gpu_ok) begin
      hot = (in_data.gpu_temp_raw > in_data.cpu_temp_raw) ?
            in_data.gpu_temp_raw[6:0] : in_data.cpu_temp_raw[6:0];
    end else if (gpu_ok) begin
      hot = in_data.gpu_temp_raw[6:0];
    end else if (cpu_ok) begin
      hot = in_data.cpu_temp_raw[6:0];
    end else begin
      hot = 7'd0;
    end
  end

  always_comb begin
    state_nxt       = state_r;
    owned_nxt       = owned_r;
    res_nxt         = res_r;
    out_valid_nxt   = out_valid_r && out_stall;
    out_nxt         = out_r;
    curve_req.start = 1'b0;
    curve_req.temp  = hot;
    curve_req.sel   = fcdc_pkg::CURVE_CUSTOM;
    if (fan_mode_r == fcdc_pkg::MODE_QUIET) begin
      curve_req.sel = fcdc_pkg::CURVE_QUIET;
    end else if (fan_mode_r == fcdc_pkg::MODE_PERF) begin
      curve_req.sel = fcdc_pkg::CURVE_PERF;
    end

    unique case (state_r)
      ST_IDLE: begin
        if (accept) begin
          res_nxt           = '0;
          res_nxt.action    = 1'b1;
          state_nxt         = ST_PUSH;
          if (fan_mode_r == fcdc_pkg::MODE_AUTO) begin
            res_nxt.action          = 1'b0;
            res_nxt.profile_request = owned_r ? fcdc_pkg::PROF_BALANCED
                                              : fcdc_pkg::PROF_NONE;
            owned_nxt               = 1'b0;
          end else if (fan_mode_r == fcdc_pkg::MODE_MANUAL) begin
            res_nxt.duty_percent = (manual_duty_r > fcdc_pkg::FULL_DUTY) ?
                                   fcdc_pkg::FULL_DUTY : manual_duty_r;
          end else begin
            if (fan_mode_r == fcdc_pkg::MODE_QUIET) begin
              res_nxt.profile_request = fcdc_pkg::PROF_QUIET;
              owned_nxt               = 1'b1;
            end else if (fan_mode_r == fcdc_pkg::MODE_PERF) begin
              res_nxt.profile_request = fcdc_pkg::PROF_PERF;
              owned_nxt               = 1'b1;
            end
            if (any_ok) begin
              res_nxt.hottest_temp = hot;
              curve_req.start      = 1'b1;
              state_nxt            = ST_CURVE;
            end else begin
              res_nxt.duty_percent = fcdc_pkg::FULL_DUTY;
              res_nxt.failsafe     = 1'b1;
            end
          end
        end
      end
      ST_CURVE: begin
        if (curve_rsp.done) begin
          res_nxt.duty_percent = curve_rsp.pct;
          state_nxt            = ST_PUSH;
        end
      end
      ST_PUSH: begin
        // hold until the output register is free
        if (out_free) begin
          out_nxt          = res_r;
          out_nxt.duty_raw = res_r.action ? fcdc_pkg::raw_of_pct(res_r.duty_percent)
                                          : 8'd0;
          out_valid_nxt    = 1'b1;
          state_nxt        = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  fcdc_curve #(
    .CurvePoints (CurvePoints)
  ) u_curve (
    .clk          (clk),
    .rst_n        (rst_n),
    .req          (curve_req),
    .curve_temps  (curve_temps_r),
    .curve_duties (curve_duties_r),
    .rsp          (curve_rsp)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fan_mode_r     <= fcdc_pkg::MODE_AUTO;
      manual_duty_r  <= fcdc_pkg::MANUAL_RESET;
      curve_temps_r  <= TempsRst;
      curve_duties_r <= DutiesRst;
    end else if (cfg_we) begin
      unique case (cfg_index)
        fcdc_pkg::REG_FAN_MODE:     fan_mode_r     <= cfg_wdata[2:0];
        fcdc_pkg::REG_MANUAL_DUTY:  manual_duty_r  <= cfg_wdata[6:0];
        fcdc_pkg::REG_CURVE_TEMPS:  curve_temps_r  <= cfg_wdata;
        fcdc_pkg::REG_CURVE_DUTIES: curve_duties_r <= cfg_wdata;
        default:                    fan_mode_r     <= fan_mode_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      owned_r     <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      owned_r     <= owned_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    res_r <= res_nxt;
    out_r <= out_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

endmodule

[src/fcdc_checker.sv]
// ----------------------------------------------------------------------------
// fcdc_checker
// Port-level checks on the result channel of the fan duty controller.
// ----------------------------------------------------------------------------
module fcdc_checker (
  input logic                clk,
  input logic                rst_n,
  input logic                out_valid,
  input logic                out_stall,
  input fcdc_pkg::out_item_t out_data
);

  // a stalled transfer keeps its result
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_data))
    else $error("result changed while stalled");

  a_auto_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_data.action |->
      out_data.duty_percent == 7'd0 && out_data.duty_raw == 8'd0 &&
      !out_data.failsafe && out_data.hottest_temp == 7'd0)
    else $error("auto hand-back carries duty fields");

  a_failsafe: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.failsafe |->
      out_data.action && out_data.duty_percent == fcdc_pkg::FULL_DUTY &&
      out_data.duty_raw == 8'd255 && out_data.hottest_temp == 7'd0)
    else $error("failsafe result without full duty");

  a_raw_floor: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.duty_percent != 7'd0 |->
      out_data.duty_raw >= fcdc_pkg::RAW_FLOOR)
    else $error("raw duty below floor");

  a_pct_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_data.duty_percent <= fcdc_pkg::FULL_DUTY &&
                  out_data.hottest_temp <= fcdc_pkg::TEMP_MAX)
    else $error("duty or temperature out of range");

endmodule

bind fan_curve_duty_controller_core fcdc_checker u_fcdc_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .out_data  (out_data)
);
